>>> design/rrva_pkg.sv
// Shared types, op codes and width helpers for the round-robin voice allocator.
package rrva_pkg;

   localparam int VOICES_DEF = 8;
   localparam int NOTES_DEF  = 128;

   localparam int OP_W       = 3;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int VSEL_W     = 3;
   localparam int VIDX_OUT_W = 3;
   localparam int CNT_OUT_W  = 4;

   localparam logic [OP_W-1:0] OP_NOTE_ON    = 3'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF   = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP_ALL   = 3'd2;
   localparam logic [OP_W-1:0] OP_VOICE_DONE = 3'd3;
   localparam logic [OP_W-1:0] OP_LOAD       = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  velocity;
      logic [VSEL_W-1:0] voice;
   } req_type;

   typedef struct packed {
      logic                  granted;
      logic [VIDX_OUT_W-1:0] voice_index;
      logic                  stolen;
      logic [CNT_OUT_W-1:0]  active_count;
   } rsp_type;

   // item as handed to the sequencer, with the loaded-map lookup already done
   typedef struct packed {
      req_type item;
      logic    on_ok;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_stat_type;

   function automatic int idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

>>> design/rrva_voice_ram.sv
// Per-voice note and velocity storage, one write and one registered read port.
module rrva_voice_ram
   import rrva_pkg::*;
#(
   parameter int DEPTH = VOICES_DEF,
   parameter int AW    = idx_w(VOICES_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [NOTE_W-1:0] wr_note,
   input  logic [VEL_W-1:0]  wr_vel,
   input  logic [AW-1:0]     rd_addr,
   output logic [NOTE_W-1:0] rd_note
);

   logic [NOTE_W-1:0] note_mem [DEPTH];
   logic [VEL_W-1:0]  vel_mem  [DEPTH];
   logic [NOTE_W-1:0] rd_note_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         note_mem[wr_addr] <= wr_note;
         vel_mem[wr_addr]  <= wr_vel;
      end
      rd_note_ff <= note_mem[rd_addr];
   end

   assign rd_note = rd_note_ff;

endmodule

>>> design/rrva_alloc_seq.sv
// Voice scan sequencer: one voice per cycle through the shared compare/count unit.
module rrva_alloc_seq
   import rrva_pkg::*;
#(
   parameter int VOICES = VOICES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  cmd_type      cmd,
   input  logic         hold,
   output seq_stat_type stat,
   output rsp_type      result
);

   localparam int VIDX_W = idx_w(VOICES);
   localparam int CNT_W  = $clog2(VOICES + 1);
   localparam int SEL_W  = (VIDX_W > VSEL_W) ? VIDX_W : VSEL_W;

   localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(VOICES);
   localparam logic [VIDX_W-1:0] LAST_IDX  = VIDX_W'(VOICES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [VOICES-1:0] active_ff, active_in;
   logic [VIDX_W-1:0] steal_ff, steal_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic              pend_ff, pend_in;
   cmd_type           cmd_ff, cmd_in;
   logic [VIDX_W-1:0] pidx_ff, pidx_in;
   logic              found_ff, found_in;
   logic [VIDX_W-1:0] pick_ff, pick_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [VIDX_W-1:0] rd_addr;
   logic [NOTE_W-1:0] rd_note;
   logic              cur_act;
   logic              keep;
   logic              grant;
   logic              steal;
   logic [VIDX_W-1:0] pick;
   logic [CNT_W-1:0]  count_out;
   logic              wr_en;

   rrva_voice_ram #(
      .DEPTH (VOICES),
      .AW    (VIDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pick),
      .wr_note (cmd_ff.item.note),
      .wr_vel  (cmd_ff.item.velocity),
      .rd_addr (rd_addr),
      .rd_note (rd_note)
   );

   assign rd_addr = step_ff[VIDX_W-1:0];
   assign cur_act = active_ff[pidx_ff];

   // a voice survives unless this item clears it
   assign keep = cur_act
               && !(cmd_ff.item.op == OP_NOTE_OFF && rd_note == cmd_ff.item.note)
               && !(cmd_ff.item.op == OP_STOP_ALL)
               && !(cmd_ff.item.op == OP_VOICE_DONE
                    && SEL_W'(cmd_ff.item.voice) == SEL_W'(pidx_ff));

   assign grant     = cmd_ff.on_ok;
   assign steal     = grant && !found_ff;
   assign pick      = found_ff ? pick_ff : steal_ff;
   assign count_out = count_ff + CNT_W'(grant && found_ff);
   assign wr_en     = (state_ff == ST_DONE) && !hold && grant;

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      steal_in  = steal_ff;
      step_in   = step_ff;
      pend_in   = pend_ff;
      cmd_in    = cmd_ff;
      pidx_in   = pidx_ff;
      found_in  = found_ff;
      pick_in   = pick_ff;
      count_in  = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = cmd;
               step_in  = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               count_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read of voice step_ff issued now, processed next cycle
            pend_in = (step_ff != LAST_STEP);
            pidx_in = rd_addr;
            if (step_ff != LAST_STEP) begin
               step_in = step_ff + 1'b1;
            end
            if (pend_ff) begin
               active_in[pidx_ff] = keep;
               count_in           = count_ff + CNT_W'(keep);
               if (!found_ff && !cur_act) begin
                  found_in = 1'b1;
                  pick_in  = pidx_ff;
               end
               if (step_ff == LAST_STEP) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!hold) begin
               if (grant) begin
                  active_in[pick] = 1'b1;
               end
               if (steal) begin
                  steal_in = (steal_ff == LAST_IDX) ? '0 : steal_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= '0;
         steal_ff  <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         steal_ff  <= steal_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      step_ff  <= step_in;
      pidx_ff  <= pidx_in;
      found_ff <= found_in;
      pick_ff  <= pick_in;
      count_ff <= count_in;
   end

   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.done = (state_ff == ST_DONE) && !hold;

   assign result.granted      = grant;
   assign result.voice_index  = grant ? VIDX_OUT_W'(pick) : '0;
   assign result.stolen       = steal;
   assign result.active_count = CNT_OUT_W'(count_out);

endmodule

>>> design/round_robin_voice_allocator.sv
// Round-robin voice allocator: loaded-note map, item intake and result register.
// Flow: the first RAM read is issued, then one compare/count step per voice runs
// through one shared unit, then the commit step loads the result register.
// req_stall is high while an item is in the scan sequencer, so a new item is taken only
// after the last one has committed. A finished result waits in the output register.
// Reset (synchronous, active high) clears all active marks, the steal pointer
// and the loaded-note map at once; no clearing pass.
module round_robin_voice_allocator
   import rrva_pkg::*;
#(
   parameter int VOICES = VOICES_DEF,
   parameter int NOTES  = NOTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NIDX_W = idx_w(NOTES);

   // one flop per note; reset clears the whole map
   logic [NOTES-1:0] loaded_ff, loaded_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              note_ok;
   logic [NIDX_W-1:0] note_idx;
   logic              hold;
   cmd_type           cmd;
   seq_stat_type      stat;
   rsp_type           result;

   assign req_stall = stat.busy;
   assign accept    = req_valid && !stat.busy;

   // notes at or above NOTES are never loaded
   assign note_ok  = (NOTE_W + 1)'(req_data.note) < (NOTE_W + 1)'(NOTES);
   assign note_idx = req_data.note[NIDX_W-1:0];

   assign cmd.item  = req_data;
   assign cmd.on_ok = (req_data.op == OP_NOTE_ON) && note_ok && loaded_ff[note_idx];

   // sequencer waits in its commit step while the previous result is unread
   assign hold = rsp_valid_ff && rsp_stall;

   rrva_alloc_seq #(
      .VOICES (VOICES)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .cmd    (cmd),
      .hold   (hold),
      .stat   (stat),
      .result (result)
   );

   always_comb begin
      loaded_in = loaded_ff;
      if (accept && req_data.op == OP_LOAD && note_ok) begin
         loaded_in[note_idx] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/rrva_checker.sv
// Port-level checks for the round-robin voice allocator, bound to the top level.
module rrva_checker
   import rrva_pkg::*;
#(
   parameter int VOICES = VOICES_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous one still scanning");

   a_no_grant_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |-> rsp_data.voice_index == '0 && !rsp_data.stolen)
      else $error("voice index or steal flag set without a grant");

   a_steal_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stolen |-> rsp_data.granted
                                      && rsp_data.active_count == CNT_OUT_W'(VOICES))
      else $error("steal reported while a voice was free");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (VOICES > 15) || rsp_data.active_count <= CNT_OUT_W'(VOICES))
      else $error("active count exceeds voice count");

endmodule

bind round_robin_voice_allocator rrva_checker #(
   .VOICES (VOICES)
) u_rrva_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
